>>> rtl/qrs_pkg.sv
// Package for the quadratic root solver: status codes and widths.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
  localparam int DiscW = 35;  // signed discriminant, |D| < 2^34
  localparam int RootW = 17;  // floor square root of D
  localparam int NumW  = 34;  // signed numerator (-b -+ r) * 2^15
  localparam int QuoW  = 33;  // signed quotient, Q17.16
  localparam int MagW  = 33;  // magnitude of numerator
  localparam int DivW  = 15;  // msb index of the magnitude of a (DivW+1 bits)
  localparam int SqIter = 17; // one result bit per stage
  localparam int DvIter = 33; // one quotient bit per stage

  typedef enum logic [1:0] {
    ST_REAL   = 2'd0,
    ST_NEG    = 2'd1,
    ST_A_ZERO = 2'd2
  } status_t;

  // Sideband of a valid bit and a status code (not used by the modules of the block).
  typedef struct packed {
    logic              valid;
    status_t           status;
  } ctl_t;
endpackage
`default_nettype wire

>>> rtl/qrs_sqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [2*qrs_pkg::RootW-1:0] radicand,
  input  wire logic [63:0]              side_in,
  output logic      [qrs_pkg::RootW-1:0] root,
  output logic      [63:0]              side_out
);
  import qrs_pkg::*;

  localparam int RadW = 2 * RootW;

  logic [RadW-1:0]  rem  [SqIter+1];
  logic [RadW-1:0]  val  [SqIter+1];
  logic [RootW-1:0] res  [SqIter+1];
  logic [63:0]      side [SqIter+1];

  assign rem[0]  = '0;
  assign val[0]  = radicand;
  assign res[0]  = '0;
  assign side[0] = side_in;

  // Each stage brings down two radicand bits and decides one root bit.
  for (genvar s = 0; s < SqIter; s++) begin : g_stage
    logic [RadW+1:0] cur;
    logic [RadW+1:0] trial;
    always_comb begin
      cur   = {rem[s], val[s][RadW-1 -: 2]};
      trial = {{(RadW+2-RootW-2){1'b0}}, res[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        side[s+1] <= side[s];
        val[s+1]  <= {val[s][RadW-3:0], 2'b00};
        if (cur >= trial) begin
          rem[s+1] <= RadW'(cur - trial);
          res[s+1] <= {res[s][RootW-2:0], 1'b1};
        end else begin
          rem[s+1] <= RadW'(cur);
          res[s+1] <= {res[s][RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root     = res[SqIter];
  assign side_out = side[SqIter];
endmodule
`default_nettype wire

>>> rtl/qrs_div.sv
// Pipelined restoring divider for unsigned magnitudes, one bit per stage.
// Depends on qrs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [qrs_pkg::MagW-1:0] num_m,
  input  wire logic [qrs_pkg::MagW-1:0] num_p,
  input  wire logic [qrs_pkg::DivW:0]   den,
  input  wire logic [7:0]               side_in,
  output logic      [qrs_pkg::MagW-1:0] quo_m,
  output logic      [qrs_pkg::MagW-1:0] quo_p,
  output logic      [7:0]               side_out
);
  import qrs_pkg::*;

  localparam int RemW = DivW + 2;

  logic [RemW-1:0] rm [DvIter+1];
  logic [RemW-1:0] rp [DvIter+1];
  logic [MagW-1:0] qm [DvIter+1];
  logic [MagW-1:0] qp [DvIter+1];
  logic [DivW:0]   dv [DvIter+1];
  logic [7:0]      sd [DvIter+1];

  assign rm[0] = '0;
  assign rp[0] = '0;
  assign qm[0] = num_m;
  assign qp[0] = num_p;
  assign dv[0] = den;
  assign sd[0] = side_in;

  // Both numerators share the divisor and walk in lockstep; the quotient
  // register shifts the dividend out and the quotient bits in.
  for (genvar s = 0; s < DvIter; s++) begin : g_stage
    logic [RemW-1:0] cm, cp;
    always_comb begin
      cm = {rm[s][RemW-2:0], qm[s][MagW-1]};
      cp = {rp[s][RemW-2:0], qp[s][MagW-1]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv[s+1] <= dv[s];
        sd[s+1] <= sd[s];
        if (cm >= {1'b0, dv[s]}) begin
          rm[s+1] <= cm - {1'b0, dv[s]};
          qm[s+1] <= {qm[s][MagW-2:0], 1'b1};
        end else begin
          rm[s+1] <= cm;
          qm[s+1] <= {qm[s][MagW-2:0], 1'b0};
        end
        if (cp >= {1'b0, dv[s]}) begin
          rp[s+1] <= cp - {1'b0, dv[s]};
          qp[s+1] <= {qp[s][MagW-2:0], 1'b1};
        end else begin
          rp[s+1] <= cp;
          qp[s+1] <= {qp[s][MagW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_m    = qm[DvIter];
  assign quo_p    = qp[DvIter];
  assign side_out = sd[DvIter];
endmodule
`default_nettype wire

>>> rtl/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, square root and
// divider pipelines. Depends on qrs_pkg, qrs_sqrt and qrs_div.
//
//   channel  direction  payload
//   s_axis   in         tdata = coef_a[15:0], coef_b[31:16], coef_c[47:32]
//   m_axis   out        tdata = status[1:0], root_minus[34:2], root_plus[67:35]
//
// One request enters per cycle while m_axis is not stalled; the pipeline is made of
// the 17 square-root stages, 33 divider stages and five more register stages.
// All stages advance together; when m_axis stalls with a full output the
// whole pipeline holds, so nothing is lost or repeated.
// Synchronous reset clears only the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // coef_a, coef_b, coef_c
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [71:0] m_axis_tdata   // status, root_minus, root_plus, pad
);
  import qrs_pkg::*;

  localparam int Lat = SqIter + DvIter + 5;

  logic en;
  logic [Lat-1:0] vld;

  // Pipeline advances unless the output holds a result nobody takes.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_axis_tvalid};
    end
  end

  // Stage 1: register inputs.
  logic signed [15:0] a1, b1, c1;
  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= s_axis_tdata[15:0];
      b1 <= s_axis_tdata[31:16];
      c1 <= s_axis_tdata[47:32];
    end
  end

  // Stage 2: products b*b and a*c.
  logic signed [31:0] bb2, ac2;
  logic signed [15:0] a2, b2;
  always_ff @(posedge clk) begin
    if (en) begin
      bb2 <= b1 * b1;
      ac2 <= a1 * c1;
      a2  <= a1;
      b2  <= b1;
    end
  end

  // Stage 3: discriminant and status.
  logic signed [DiscW-1:0] d3;
  logic signed [15:0] a3, b3;
  status_t st3;
  always_comb begin
    d3 = DiscW'(bb2) - (DiscW'(ac2) <<< 2);
  end
  logic signed [DiscW-1:0] d3r;
  always_ff @(posedge clk) begin
    if (en) begin
      d3r <= d3;
      a3  <= a2;
      b3  <= b2;
      if (a2 == '0)        st3 <= ST_A_ZERO;
      else if (d3[DiscW-1]) st3 <= ST_NEG;
      else                 st3 <= ST_REAL;
    end
  end

  // Square root pipeline; a, b and status ride along.
  logic [2*RootW-1:0] rad;
  logic [RootW-1:0]   r4;
  logic [63:0]        sq_side_in, sq_side_out;
  assign rad        = d3r[DiscW-1] ? '0 : d3r[2*RootW-1:0];
  assign sq_side_in = {30'd0, st3, a3, b3};

  qrs_sqrt u_sqrt (
    .clk(clk), .en(en), .radicand(rad), .side_in(sq_side_in),
    .root(r4), .side_out(sq_side_out)
  );

  logic signed [15:0] a4, b4;
  status_t st4;
  assign b4  = sq_side_out[15:0];
  assign a4  = sq_side_out[31:16];
  assign st4 = status_t'(sq_side_out[33:32]);

  // Stage: numerators and their magnitudes, signs of the numerators and of a.
  logic signed [18:0] sm, sp;
  logic [MagW-1:0] mm5, mp5;
  logic [DivW:0]   den5;
  logic [7:0]      dv_side_in, dv_side_out;
  logic            nm_neg, np_neg, a_neg;
  status_t         st5;
  always_comb begin
    sm = -19'(b4) - 19'(signed'({1'b0, r4}));
    sp = -19'(b4) + 19'(signed'({1'b0, r4}));
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mm5    <= {(sm[18] ? 18'(-sm) : 18'(sm)), 15'd0};
      mp5    <= {(sp[18] ? 18'(-sp) : 18'(sp)), 15'd0};
      den5   <= a4[15] ? 16'(-a4) : 16'(a4);
      nm_neg <= sm[18];
      np_neg <= sp[18];
      a_neg  <= a4[15];
      st5    <= st4;
    end
  end
  assign dv_side_in = {3'd0, a_neg, np_neg, nm_neg, st5};

  logic [MagW-1:0] qm6, qp6;
  qrs_div u_div (
    .clk(clk), .en(en), .num_m(mm5), .num_p(mp5), .den(den5),
    .side_in(dv_side_in), .quo_m(qm6), .quo_p(qp6), .side_out(dv_side_out)
  );

  // Final stage: apply signs, zero roots for special status.
  logic [QuoW-1:0] rm7, rp7;
  status_t st7;
  always_ff @(posedge clk) begin
    if (en) begin
      st7 <= status_t'(dv_side_out[1:0]);
      if (status_t'(dv_side_out[1:0]) != ST_REAL) begin
        rm7 <= '0;
        rp7 <= '0;
      end else begin
        rm7 <= (dv_side_out[2] ^ dv_side_out[4]) ? QuoW'(-qm6) : qm6;
        rp7 <= (dv_side_out[3] ^ dv_side_out[4]) ? QuoW'(-qp6) : qp6;
      end
    end
  end

  assign m_axis_tdata = {4'd0, rp7, rm7, st7};

`ifndef SYNTHESIS
  a_neg_zero : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && st7 != ST_REAL |-> rm7 == '0 && rp7 == '0)
    else $error("special status with nonzero roots");
  a_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline moved while stalled");
  a_ready : assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");
`endif
endmodule
`default_nettype wire
